>>> sv/srd_pkg.sv
// shared types, constants and the fill-emit helper of the snapshot stream decoder
// no dependencies; compiled first
package srd_pkg;

  // file format constants
  localparam logic [7:0]  EscByte   = 8'hED;
  localparam logic [7:0]  CompBit   = 8'h20;
  localparam logic [15:0] HdrLen    = 16'd30;
  localparam logic [15:0] RawMark   = 16'hFFFF;
  localparam logic [15:0] RawLen    = 16'h4000;
  localparam logic [15:0] OldBase   = 16'h4000;
  localparam logic [15:0] Page4Base = 16'h8000;
  localparam logic [15:0] Page5Base = 16'hC000;
  localparam logic [15:0] Page8Base = 16'h4000;
  localparam logic [7:0]  PageFour  = 8'd4;
  localparam logic [7:0]  PageFive  = 8'd5;
  localparam logic [7:0]  PageEight = 8'd8;

  // result queue depth (power of two, at least 2; 4 or more for full rate)
  localparam int FifoDepth = 4;

  typedef struct packed {
    logic [15:0] write_addr;
    logic [7:0]  fill_value;
    logic [7:0]  repeat_count;
    logic        last_of_item;
  } res_t;

  // fills collected while one byte is decoded
  typedef struct packed {
    logic [1:0]       n;
    logic [15:0]      addr;
    res_t [1:0]       res;
  } emit_acc_t;

  // append one fill unless the count is zero; advances the running address
  function automatic emit_acc_t srd_emit(emit_acc_t acc, logic [7:0] value,
                                         logic [7:0] count);
    emit_acc_t r;
    r = acc;
    if (count != 8'd0 && acc.n < 2'd2) begin
      r.res[acc.n[0]] = '{write_addr: acc.addr, fill_value: value,
                          repeat_count: count, last_of_item: 1'b0};
      r.addr = acc.addr + {8'd0, count};
      r.n    = acc.n + 2'd1;
    end
    return r;
  endfunction

endpackage

>>> sv/srd_if.sv
// valid/ready channel interfaces for the snapshot stream decoder
// input beat carries one file byte, output beat carries one fill command
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface srd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] write_addr;
  logic [7:0]  fill_value;
  logic [7:0]  repeat_count;
  logic        last_of_item;

  modport source (output valid, output write_addr, output fill_value,
                  output repeat_count, output last_of_item, input ready);
  modport sink   (input valid, input write_addr, input fill_value,
                  input repeat_count, input last_of_item, output ready);
endinterface

>>> sv/srd_parser.sv
// file parser: header skip, block headers and escape decoding, one byte per step
// depends on srd_pkg
module srd_parser import srd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             final_byte_i,
  output res_t [1:0]       res_o,
  output logic [1:0]       res_cnt_o
);

  localparam logic [2:0] PhHeader   = 3'd0;
  localparam logic [2:0] PhExtLen   = 3'd1;
  localparam logic [2:0] PhExtSkip  = 3'd2;
  localparam logic [2:0] PhBlkHdr   = 3'd3;
  localparam logic [2:0] PhBlkData  = 3'd4;
  localparam logic [2:0] PhOldData  = 3'd5;

  // escape progress; also the byte index in length and block headers
  localparam logic [1:0] EscIdle  = 2'd0;
  localparam logic [1:0] EscOne   = 2'd1;
  localparam logic [1:0] EscTwo   = 2'd2;
  localparam logic [1:0] EscCount = 2'd3;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic        newfmt_q, newfmt_d;
  logic        comp_q, comp_d;
  logic [15:0] addr_q, addr_d;
  logic [1:0]  esc_q, esc_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  lowb_q, lowb_d;

  emit_acc_t   acc;
  logic [15:0] len;
  logic        cut;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    newfmt_d = newfmt_q;
    comp_d   = comp_q;
    esc_d    = esc_q;
    pend_d   = pend_q;
    lowb_d   = lowb_q;
    acc      = '{n: 2'd0, addr: addr_q, res: '0};
    len      = {data_byte_i, lowb_q};
    cut      = 1'b0;

    // body byte decode, raw or escaped
    if (step_i && (phase_q == PhBlkData || phase_q == PhOldData)) begin
      if (!comp_q) begin
        acc = srd_emit(acc, data_byte_i, 8'd1);
      end else begin
        unique case (esc_q)
          EscIdle: begin
            if (data_byte_i != EscByte) acc = srd_emit(acc, data_byte_i, 8'd1);
            else esc_d = EscOne;
          end
          EscOne: begin
            if (data_byte_i != EscByte) begin
              acc   = srd_emit(acc, EscByte, 8'd1);
              acc   = srd_emit(acc, data_byte_i, 8'd1);
              esc_d = EscIdle;
            end else begin
              esc_d = EscTwo;
            end
          end
          EscTwo: begin
            pend_d = data_byte_i;
            esc_d  = EscCount;
          end
          default: begin
            acc    = srd_emit(acc, data_byte_i, pend_q);
            pend_d = 8'd0;
            esc_d  = EscIdle;
          end
        endcase
      end
    end

    if (step_i) begin
      unique case (phase_q)
        PhHeader: begin
          if (cnt_q == 16'd6)  lowb_d   = data_byte_i;
          if (cnt_q == 16'd7)  newfmt_d = ((lowb_q | data_byte_i) == 8'd0);
          if (cnt_q == 16'd12) comp_d   = ((data_byte_i & CompBit) != 8'd0);
          cnt_d = cnt_q + 16'd1;
          if (cnt_d >= HdrLen) begin
            cnt_d    = 16'd0;
            esc_d    = EscIdle;
            pend_d   = 8'd0;
            acc.addr = OldBase;
            phase_d  = newfmt_d ? PhExtLen : PhOldData;
          end
        end
        PhExtLen: begin
          if (esc_q == EscIdle) begin
            lowb_d = data_byte_i;
            esc_d  = EscOne;
          end else begin
            esc_d   = EscIdle;
            cnt_d   = len;
            phase_d = (len != 16'd0) ? PhExtSkip : PhBlkHdr;
          end
        end
        PhExtSkip: begin
          cnt_d = cnt_q - 16'd1;
          if (cnt_d == 16'd0) phase_d = PhBlkHdr;
        end
        PhBlkHdr: begin
          if (esc_q == EscIdle) begin
            lowb_d = data_byte_i;
            esc_d  = EscOne;
          end else if (esc_q == EscOne) begin
            if (len == RawMark) begin
              cnt_d  = RawLen;
              comp_d = 1'b0;
            end else begin
              cnt_d  = len;
              comp_d = 1'b1;
            end
            esc_d = EscTwo;
          end else begin
            if (data_byte_i == PageFour)       acc.addr = Page4Base;
            else if (data_byte_i == PageFive)  acc.addr = Page5Base;
            else if (data_byte_i == PageEight) acc.addr = Page8Base;
            else                               acc.addr = 16'd0;
            esc_d  = EscIdle;
            pend_d = 8'd0;
            if (cnt_q != 16'd0) phase_d = PhBlkData;
          end
        end
        PhBlkData: begin
          cnt_d = cnt_q - 16'd1;
          if (cnt_d == 16'd0) begin
            cut     = 1'b1;
            phase_d = PhBlkHdr;
          end
        end
        PhOldData: begin
          phase_d = PhOldData;
        end
        default: begin
          phase_d  = PhHeader;
          cnt_d    = 16'd0;
          newfmt_d = 1'b0;
          comp_d   = 1'b0;
          acc.addr = OldBase;
          esc_d    = EscIdle;
          pend_d   = 8'd0;
          lowb_d   = 8'd0;
        end
      endcase

      if (final_byte_i && (phase_d == PhBlkData || phase_d == PhOldData)) cut = 1'b1;

      // escape cut at block or file end: a lone escape byte becomes a literal
      if (cut) begin
        if (comp_d && esc_d == EscOne) acc = srd_emit(acc, EscByte, 8'd1);
        esc_d  = EscIdle;
        pend_d = 8'd0;
      end
    end

    addr_d = acc.addr;

    if (step_i && final_byte_i) begin
      phase_d  = PhHeader;
      cnt_d    = 16'd0;
      newfmt_d = 1'b0;
      comp_d   = 1'b0;
      addr_d   = OldBase;
      esc_d    = EscIdle;
      pend_d   = 8'd0;
      lowb_d   = 8'd0;
    end

    res_o     = acc.res;
    res_cnt_o = acc.n;
    if (acc.n == 2'd1) res_o[0].last_of_item = 1'b1;
    if (acc.n == 2'd2) res_o[1].last_of_item = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      cnt_q    <= 16'd0;
      newfmt_q <= 1'b0;
      comp_q   <= 1'b0;
      addr_q   <= OldBase;
      esc_q    <= EscIdle;
      pend_q   <= 8'd0;
      lowb_q   <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      newfmt_q <= newfmt_d;
      comp_q   <= comp_d;
      addr_q   <= addr_d;
      esc_q    <= esc_d;
      pend_q   <= pend_d;
      lowb_q   <= lowb_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && final_byte_i |=> phase_q == PhHeader && addr_q == OldBase && esc_q == EscIdle)
    else $error("parser not back at header start after final byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o != 2'd0 |-> step_i)
    else $error("fill produced without a decode step");

endmodule

>>> sv/srd_result_fifo.sv
// small result queue: takes up to two fills per cycle, hands out one per beat
// depends on srd_pkg
module srd_result_fifo import srd_pkg::*; #(
  parameter int DEPTH = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t [1:0] push_data_i,
  output logic       room_o,
  output logic       valid_o,
  output res_t       head_o,
  input  logic       pop_i
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  res_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_ptr_nx;
  logic            pop;

  assign pop       = pop_i && (count_q != '0);
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);
  assign room_o    = (count_q <= CntW'(DEPTH - 2));
  assign valid_o   = (count_q != '0);
  assign head_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_ptr_q]  <= push_data_i[0];
    if (push_cnt_i == 2'd2) mem_q[wr_ptr_nx] <= push_data_i[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> room_o)
    else $error("push into queue without room for two fills");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue occupancy above depth");

endmodule

>>> sv/snapshot_rle_stream_decoder_top.sv
// snapshot stream decoder: file bytes in, memory fill commands out
// an accepted byte waits in the input register; the parser decodes it and its fills are queued
// throughput: one byte per cycle while the queue has room and each byte gives at
//   most one fill; a two-fill byte takes two output beats, the queue absorbs this
// reset: asynchronous active low; parser returns to the header start, queue empties
// depends on srd_pkg, srd_if, srd_parser, srd_result_fifo
module snapshot_rle_stream_decoder_top import srd_pkg::*; #(
  parameter int FIFO_DEPTH = FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srd_in_if.sink      in_i,
  srd_out_if.source   out_o
);

  // input register: one file byte waiting for the parser
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_fin_q;

  logic       in_take;
  logic       advance;

  // parser results for the byte in the input register
  res_t [1:0] res;
  logic [1:0] res_cnt;

  // queue side
  logic       room;
  logic       head_vld;
  res_t       head;

  // a byte moves into the parser only if the queue can take both possible fills
  assign advance   = in_vld_q && room;
  assign in_i.ready = !in_vld_q || advance;
  assign in_take   = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)      in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.data_byte;
      in_fin_q  <= in_i.final_byte;
    end
  end

  // header skip, block headers and escape decode; state steps once per byte
  srd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (in_byte_q),
    .final_byte_i (in_fin_q),
    .res_o        (res),
    .res_cnt_o    (res_cnt)
  );

  // fills wait here until the sink takes them, one per beat
  srd_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_data_i (res),
    .room_o      (room),
    .valid_o     (head_vld),
    .head_o      (head),
    .pop_i       (out_o.ready)
  );

  assign out_o.valid        = head_vld;
  assign out_o.write_addr   = head.write_addr;
  assign out_o.fill_value   = head.fill_value;
  assign out_o.repeat_count = head.repeat_count;
  assign out_o.last_of_item = head.last_of_item;

  // a byte held back by a full queue stays in the input register unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q) && $stable(in_fin_q))
    else $error("stalled input byte lost or changed");

  // no fill leaves the block with a zero repeat count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.repeat_count != 8'd0)
    else $error("fill with zero repeat count");

endmodule

>>> test/srd_checker.sv
`timescale 1ns / 1ps
// fill command checker for the snapshot stream decoder testbench
// predicts the fills of each accepted file byte and compares them with the output beats
// depends on srd_pkg
module srd_checker import srd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] write_addr_i,
  input  logic [7:0]  fill_value_i,
  input  logic [7:0]  repeat_count_i,
  input  logic        last_of_item_i,
  output int          errors_o,
  output int          outstanding_o
);

  typedef enum logic [2:0] {
    HdrScan, ExtLen, ExtSkip, BlkHdr, BlkData, OldData
  } parse_phase_e;

  // escape progress inside a data body
  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscOne   = 2'd1;
  localparam logic [1:0] EscTwo   = 2'd2;
  localparam logic [1:0] EscCount = 2'd3;

  // header offsets
  localparam logic [15:0] PcLoPos  = 16'd6;
  localparam logic [15:0] PcHiPos  = 16'd7;
  localparam logic [15:0] FlagsPos = 16'd12;

  parse_phase_e phase;
  logic [15:0]  pos_count;
  logic         new_fmt;
  logic         rle_on;
  logic [15:0]  fill_addr;
  logic [1:0]   esc_cnt;
  logic [1:0]   field_idx;
  logic [7:0]   run_len;
  logic [7:0]   low_save;

  res_t fills_now [2];
  int   fills_n;
  res_t fill_queue [$];

  task automatic report(input string what);
    $display("tb: mismatch at %0t ns: %s", $time, what);
    errors_o++;
  endtask

  task automatic reset_decoder();
    phase     = HdrScan;
    pos_count = 16'd0;
    new_fmt   = 1'b0;
    rle_on    = 1'b0;
    fill_addr = OldBase;
    esc_cnt   = EscNone;
    field_idx = 2'd0;
    run_len   = 8'd0;
    low_save  = 8'd0;
  endtask

  task automatic add_fill(input logic [7:0] value, input logic [7:0] count);
    if (fills_n < 2 && count != 8'd0) begin
      fills_now[fills_n] = '{write_addr: fill_addr, fill_value: value,
                             repeat_count: count, last_of_item: 1'b0};
      fill_addr = fill_addr + {8'd0, count};
      fills_n++;
    end
  endtask

  task automatic expand_body_byte(input logic [7:0] b);
    if (!rle_on) begin
      add_fill(b, 8'd1);
    end else begin
      case (esc_cnt)
        EscNone: begin
          if (b != EscByte) add_fill(b, 8'd1);
          else esc_cnt = EscOne;
        end
        EscOne: begin
          if (b != EscByte) begin
            add_fill(EscByte, 8'd1);
            add_fill(b, 8'd1);
            esc_cnt = EscNone;
          end else begin
            esc_cnt = EscTwo;
          end
        end
        EscTwo: begin
          run_len = b;
          esc_cnt = EscCount;
        end
        default: begin
          add_fill(b, run_len);
          run_len = 8'd0;
          esc_cnt = EscNone;
        end
      endcase
    end
  endtask

  // a lone pending escape byte is a literal, a longer pending escape is dropped
  task automatic cut_run();
    if (rle_on && esc_cnt == EscOne) add_fill(EscByte, 8'd1);
    esc_cnt = EscNone;
    run_len = 8'd0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [15:0] blk_len;
    fills_n = 0;
    case (phase)
      HdrScan: begin
        if (pos_count == PcLoPos) low_save = b;
        if (pos_count == PcHiPos) new_fmt = ((low_save | b) == 8'd0);
        if (pos_count == FlagsPos) rle_on = ((b & CompBit) != 8'd0);
        pos_count++;
        if (pos_count >= HdrLen) begin
          pos_count = 16'd0;
          esc_cnt   = EscNone;
          run_len   = 8'd0;
          fill_addr = OldBase;
          if (new_fmt) phase = ExtLen;
          else phase = OldData;
        end
      end
      ExtLen: begin
        if (field_idx == 2'd0) begin
          low_save  = b;
          field_idx = 2'd1;
        end else begin
          field_idx = 2'd0;
          pos_count = {b, low_save};
          if (pos_count != 16'd0) phase = ExtSkip;
          else phase = BlkHdr;
        end
      end
      ExtSkip: begin
        pos_count--;
        if (pos_count == 16'd0) phase = BlkHdr;
      end
      BlkHdr: begin
        if (field_idx == 2'd0) begin
          low_save  = b;
          field_idx = 2'd1;
        end else if (field_idx == 2'd1) begin
          blk_len = {b, low_save};
          if (blk_len == RawMark) begin
            pos_count = RawLen;
            rle_on    = 1'b0;
          end else begin
            pos_count = blk_len;
            rle_on    = 1'b1;
          end
          field_idx = 2'd2;
        end else begin
          case (b)
            PageFour:  fill_addr = Page4Base;
            PageFive:  fill_addr = Page5Base;
            PageEight: fill_addr = Page8Base;
            default:   fill_addr = 16'h0000;
          endcase
          field_idx = 2'd0;
          esc_cnt   = EscNone;
          run_len   = 8'd0;
          if (pos_count != 16'd0) phase = BlkData;
        end
      end
      BlkData: begin
        expand_body_byte(b);
        pos_count--;
        if (pos_count == 16'd0) begin
          cut_run();
          phase = BlkHdr;
        end
      end
      OldData: expand_body_byte(b);
      default: reset_decoder();
    endcase
    if (fin) begin
      if (phase == BlkData || phase == OldData) cut_run();
      reset_decoder();
    end
    for (int i = 0; i < fills_n; i++) begin
      if (i == fills_n - 1) fills_now[i].last_of_item = 1'b1;
      fill_queue.push_back(fills_now[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      reset_decoder();
      fill_queue.delete();
      errors_o      = 0;
      outstanding_o = 0;
    end else begin
      // output first: a fill never leaves on the edge its byte enters
      if (out_valid_i && out_ready_i) begin
        if (fill_queue.size() == 0) begin
          report($sformatf("unexpected fill addr %h value %h count %h last %b",
                           write_addr_i, fill_value_i, repeat_count_i, last_of_item_i));
        end else begin
          want = fill_queue.pop_front();
          if (write_addr_i !== want.write_addr)
            report($sformatf("write_addr %h, want %h", write_addr_i, want.write_addr));
          if (fill_value_i !== want.fill_value)
            report($sformatf("fill_value %h, want %h", fill_value_i, want.fill_value));
          if (repeat_count_i !== want.repeat_count)
            report($sformatf("repeat_count %h, want %h", repeat_count_i,
                             want.repeat_count));
          if (last_of_item_i !== want.last_of_item)
            report($sformatf("last_of_item %b, want %b", last_of_item_i,
                             want.last_of_item));
        end
      end
      if (in_valid_i && in_ready_i) predict_byte(data_byte_i, final_byte_i);
      outstanding_o = fill_queue.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// top of the snapshot stream decoder testbench: clock, reset, file byte stimulus, verdict
// depends on srd_pkg, srd_if, srd_checker and the decoder rtl
module tb;
  import srd_pkg::*;

  // traffic shaping modes of the two channel ends
  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  localparam int HeavyPct    = 73;      // idle or stall share in the one-sided modes
  localparam int LightPct    = 14;      // share on both ends in the mixed mode
  localparam int LongHold    = 300;     // receiver hold-off, in cycles
  localparam int DrainCycles = 20;      // settle time after the last expected fill
  localparam int CycleLimit  = 200000;  // watchdog, far above the slowest correct run
  localparam int ItemTarget  = 450;     // input bytes to send over the whole run
  localparam int WrapRuns    = 66;      // max-count runs that carry page five past 0xffff

  logic clk_i;
  logic rst_ni;

  srd_in_if  in_bus ();
  srd_out_if out_bus ();

  int mismatches;
  int fills_owed;

  // knobs shared between the stimulus and the receiver
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;

  // file image under construction and a block body scratch queue
  logic [7:0] file_buf [$];
  logic [7:0] blk_buf [$];
  int         items_sent;

  snapshot_rle_stream_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  srd_checker fill_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_bus.valid),
    .in_ready_i     (in_bus.ready),
    .data_byte_i    (in_bus.data_byte),
    .final_byte_i   (in_bus.final_byte),
    .out_valid_i    (out_bus.valid),
    .out_ready_i    (out_bus.ready),
    .write_addr_i   (out_bus.write_addr),
    .fill_value_i   (out_bus.fill_value),
    .repeat_count_i (out_bus.repeat_count),
    .last_of_item_i (out_bus.last_of_item),
    .errors_o       (mismatches),
    .outstanding_o  (fills_owed)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: nothing else may run this long
  initial begin
    int cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  initial begin
    int hold_left;
    int hold_ack;
    hold_left = 0;
    hold_ack  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // any byte but the escape byte, so a literal stays a literal
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = rand_byte();
    while (b == EscByte) b = rand_byte();
    return b;
  endfunction

  // mostly the three mapped pages, sometimes any other page number
  function automatic logic [7:0] pick_page();
    case ($urandom_range(3))
      0: return PageFour;
      1: return PageFive;
      2: return PageEight;
      default: return rand_byte();
    endcase
  endfunction

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IdleNone: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IdleSender: begin
        send_idle_pct = HeavyPct;
        recv_stall_pct <= 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        recv_stall_pct <= HeavyPct;
      end
      default: begin
        send_idle_pct = LightPct;
        recv_stall_pct <= LightPct;
      end
    endcase
  endtask

  // one beat on the input channel; returns at the edge that accepted it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.final_byte <= fin;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // sender stops and waits for every predicted fill to leave the block
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (fills_owed != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // the file image, marked final on its last byte; a random prefix when cut is allowed
  task automatic send_file(input bit may_cut);
    int n;
    n = file_buf.size();
    if (may_cut && $urandom_range(5) == 0) n = $urandom_range(1, n);
    for (int i = 0; i < n; i++) send_byte(file_buf[i], i == n - 1);
  endtask

  // 30-byte main header with random content; the pc word and the flag bit are steered
  task automatic add_header(input bit new_fmt, input bit rle);
    logic [7:0] b;
    for (int i = 0; i < HdrLen; i++) begin
      b = rand_byte();
      if (i == 6 && new_fmt) b = 8'h00;
      if (i == 7) begin
        if (new_fmt) b = 8'h00;
        else if (file_buf[6] == 8'h00 && b == 8'h00) b = 8'h01;
      end
      if (i == 12) b[5] = rle;
      file_buf.push_back(b);
    end
  endtask

  // well-formed escape-coded tokens into the block body
  task automatic add_rle(input int n_tok);
    logic [7:0] cnt;
    repeat (n_tok) begin
      case ($urandom_range(9))
        0, 1, 2, 3: blk_buf.push_back(plain_byte());
        4: begin
          // lone escape byte followed by a literal
          blk_buf.push_back(EscByte);
          blk_buf.push_back(plain_byte());
        end
        default: begin
          case ($urandom_range(5))
            0: cnt = 8'd0;
            1: cnt = 8'd255;
            default: cnt = rand_byte();
          endcase
          blk_buf.push_back(EscByte);
          blk_buf.push_back(EscByte);
          blk_buf.push_back(cnt);
          blk_buf.push_back(rand_byte());
        end
      endcase
    end
  endtask

  // sometimes leave an escape unfinished at the end of a body
  task automatic add_cut_tail();
    logic [1:0] k;
    k = 2'($urandom_range(3));
    if (k >= 2'd1) blk_buf.push_back(EscByte);
    if (k >= 2'd2) blk_buf.push_back(EscByte);
    if (k == 2'd3) blk_buf.push_back(rand_byte());
  endtask

  task automatic add_block(input logic [15:0] len, input logic [7:0] page);
    file_buf.push_back(len[7:0]);
    file_buf.push_back(len[15:8]);
    file_buf.push_back(page);
    foreach (blk_buf[i]) file_buf.push_back(blk_buf[i]);
  endtask

  task automatic build_new_file();
    int ext_len;
    int n_blk;
    file_buf.delete();
    add_header(1'b1, 1'($urandom_range(1)));
    ext_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
    file_buf.push_back(ext_len[7:0]);
    file_buf.push_back(ext_len[15:8]);
    repeat (ext_len) file_buf.push_back(rand_byte());
    n_blk = $urandom_range(1, 4);
    repeat (n_blk) begin
      blk_buf.delete();
      if ($urandom_range(5) != 0) begin
        add_rle($urandom_range(1, 8));
        add_cut_tail();
      end
      add_block(16'(blk_buf.size()), pick_page());
    end
    // how the file ends: at a block boundary, inside a raw block, inside a coded block
    case ($urandom_range(2))
      0: ;
      1: begin
        blk_buf.delete();
        repeat ($urandom_range(1, 12)) blk_buf.push_back(rand_byte());
        add_block(RawMark, pick_page());
      end
      default: begin
        blk_buf.delete();
        add_rle($urandom_range(1, 6));
        add_cut_tail();
        add_block(16'(blk_buf.size() + $urandom_range(1, 20)), pick_page());
      end
    endcase
  endtask

  task automatic build_old_file();
    bit rle;
    file_buf.delete();
    blk_buf.delete();
    rle = 1'($urandom_range(1));
    add_header(1'b0, rle);
    if (rle) begin
      add_rle($urandom_range(4, 20));
      add_cut_tail();
    end else begin
      // raw body: escape bytes are plain data here
      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(4) == 0) blk_buf.push_back(EscByte);
        else blk_buf.push_back(rand_byte());
      end
    end
    foreach (blk_buf[i]) file_buf.push_back(blk_buf[i]);
  endtask

  // long coded block at page five whose runs wrap the address past 0xffff
  task automatic build_wrap_file();
    file_buf.delete();
    blk_buf.delete();
    add_header(1'b1, 1'($urandom_range(1)));
    file_buf.push_back(8'h00);
    file_buf.push_back(8'h00);
    repeat (WrapRuns) begin
      blk_buf.push_back(EscByte);
      blk_buf.push_back(EscByte);
      blk_buf.push_back(8'd255);
      blk_buf.push_back(rand_byte());
    end
    add_block(16'(blk_buf.size()), PageFive);
    // final lands on the first byte of the next block header
    file_buf.push_back(rand_byte());
  endtask

  // junk: random bytes with scattered final marks, often dying inside the header
  task automatic send_noise();
    int n;
    n = $urandom_range(5, 60);
    for (int i = 0; i < n; i++) begin
      send_byte(rand_byte(), (i == n - 1) || ($urandom_range(39) == 0));
    end
  endtask

  initial begin
    int file_no;
    int sel;
    idle_mode_e mode;
    idle_mode_e last_mode;

    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= 8'h00;
    in_bus.final_byte <= 1'b0;
    hold_req          <= 0;
    recv_stall_pct    <= 0;
    send_idle_pct     = 0;
    items_sent        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed file, new format, sent against a stalling receiver:
    // header of alternating 0xff / 0x00 with a zero pc word, empty extended header,
    // an empty block, then coded blocks on pages 5, 4 and an unmapped one
    set_idle_mode(IdleReceiver);
    file_buf.delete();
    for (int i = 0; i < HdrLen; i++) begin
      if (i == 6 || i == 7) file_buf.push_back(8'h00);
      else file_buf.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
    end
    file_buf = {file_buf, 8'h00, 8'h00};                  // extended length zero
    file_buf = {file_buf, 8'h00, 8'h00, PageEight};       // zero-length block
    // literals at both extremes, lone escape, zero count, max count, escaped value
    // equal to the escape byte, and a lone escape cut at the block end
    file_buf = {file_buf, 8'd17, 8'h00, PageFive,
                8'h00, 8'hFF, EscByte, 8'h12,
                EscByte, EscByte, 8'h00, 8'h77,
                EscByte, EscByte, 8'hFF, 8'hAA,
                EscByte, EscByte, 8'h03, EscByte,
                EscByte};
    // run with its count already read, dropped at the block end
    file_buf = {file_buf, 8'd5, 8'h00, PageFour,
                8'h11, 8'h22, EscByte, EscByte, 8'h05};
    // unmapped page, file ends on a lone escape
    file_buf = {file_buf, 8'd10, 8'h00, 8'h03, 8'h33, EscByte};
    send_file(1'b0);
    wait_drained();

    // long hold-off while the sender keeps offering the wrapping file at full rate:
    // the result queue fills and the input has to stall
    set_idle_mode(IdleNone);
    hold_req <= hold_req + 1;
    build_wrap_file();
    send_file(1'b0);
    wait_drained();

    // random part: one old and one new file first, then files of both formats,
    // cut files and junk, with the idle mode changing every file
    file_no   = 0;
    last_mode = IdleNone;
    while (items_sent < ItemTarget || file_no < 2) begin
      case (file_no % 4)
        0: mode = IdleSender;
        1: mode = IdleBoth;
        2: mode = IdleNone;
        default: mode = IdleReceiver;
      endcase
      if (mode != last_mode) wait_drained();
      set_idle_mode(mode);
      last_mode = mode;
      if (file_no == 0) sel = 1;
      else if (file_no == 1) sel = 4;
      else sel = $urandom_range(9);
      case (sel)
        0: send_noise();
        1, 2, 3: begin
          build_old_file();
          send_file(1'b1);
        end
        default: begin
          build_new_file();
          send_file(1'b1);
        end
      endcase
      file_no++;
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && fills_owed == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/srd_pkg.sv
sv/srd_if.sv
sv/srd_parser.sv
sv/srd_result_fifo.sv
sv/snapshot_rle_stream_decoder_top.sv
test/srd_checker.sv
test/tb.sv
